// File: hdl/gpd_pkg.sv
// Package for the galvo point-to-DAC block: widths, constants, register codes
// and the CORDIC angle table. Used by every other file of the block.
// No dependencies.
`default_nettype none

package gpd_pkg;

    localparam int COORD_BITS      = 24;
    localparam int DAC_BITS        = 12;
    localparam int ANGLE_BITS      = 18;
    localparam int ANGLE_MAG_BITS  = 17;
    localparam int OFFSET_BITS     = 23;
    localparam int FRAC_SHIFT      = 8;

    localparam logic [ANGLE_MAG_BITS-1:0] QUARTER_PI  = 17'd102943;
    localparam logic [ANGLE_MAG_BITS-1:0] LIMIT_RESET = 17'd22876;

    // Square root: 40 digit steps, the last 8 bring in zero pairs.
    localparam int SUM_BITS        = 64;
    localparam int ROOT_STEPS      = 40;
    localparam int ROOT_BITS       = 40;
    localparam int ROOT_ZERO_STEPS = 8;
    localparam int REM_BITS        = 44;

    // Arctangent: operands below 2^42, normalized into [2^57, 2^58).
    localparam int ATAN_IN_BITS    = 42;
    localparam int NORM_BITS       = 58;
    localparam int NORM_STAGES     = 3;
    localparam int CORDIC_STEPS    = 17;
    localparam int CORDIC_BITS     = 62;
    localparam int ACC_BITS        = 19;

    // Mapping numerator, 0 .. 2*limit.
    localparam int NUM_BITS        = 18;

    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    typedef enum logic [1:0] {
        REG_MIRROR_OFFSET,
        REG_ANGLE_LIMIT,
        REG_INVERT_X,
        REG_INVERT_Z
    } reg_index_t;

    function automatic logic [ANGLE_MAG_BITS-1:0] atan_step(input int unsigned i);
        logic [ANGLE_MAG_BITS-1:0] v;
        case (i)
            0:       v = 17'd51472;
            1:       v = 17'd30386;
            2:       v = 17'd16055;
            3:       v = 17'd8150;
            4:       v = 17'd4091;
            5:       v = 17'd2047;
            6:       v = 17'd1024;
            7:       v = 17'd512;
            8:       v = 17'd256;
            9:       v = 17'd128;
            10:      v = 17'd64;
            11:      v = 17'd32;
            12:      v = 17'd16;
            13:      v = 17'd8;
            14:      v = 17'd4;
            15:      v = 17'd2;
            16:      v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gpd_point_if.sv
// Input channel of the galvo point-to-DAC block: valid/ready and one point.
// Depends on gpd_pkg.
`default_nettype none

interface gpd_point_if #(
    parameter int COORD_BITS = gpd_pkg::COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/gpd_result_if.sv
// Output channel of the galvo point-to-DAC block: valid/ready, DAC codes, angles.
// Depends on gpd_pkg.
`default_nettype none

interface gpd_result_if #(
    parameter int DAC_BITS = gpd_pkg::DAC_BITS
) ();
    logic                                  valid;
    logic                                  ready;
    logic [DAC_BITS-1:0]                   dac_x;
    logic [DAC_BITS-1:0]                   dac_z;
    logic signed [gpd_pkg::ANGLE_BITS-1:0] angle_x;
    logic signed [gpd_pkg::ANGLE_BITS-1:0] angle_z;

    modport source (output valid, output dac_x, output dac_z, output angle_x,
                    output angle_z, input ready);
    modport sink   (input valid, input dac_x, input dac_z, input angle_x,
                    input angle_z, output ready);
endinterface

`default_nettype wire

// File: hdl/gpd_sqrt.sv
// Pipelined square root of ay^2 + az^2 with 8 extra fraction bits, one digit
// per stage, carrying a side payload. Depends on gpd_pkg.
`default_nettype none

module gpd_sqrt #(
    parameter int COORD_BITS = gpd_pkg::COORD_BITS,
    parameter int PAY_BITS   = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [COORD_BITS-1:0]             in_ay,
    input  wire logic [COORD_BITS-1:0]             in_az,
    input  wire logic [PAY_BITS-1:0]               in_pay,
    output logic                                   out_valid,
    output logic [gpd_pkg::ROOT_BITS-1:0]          out_root,
    output logic [PAY_BITS-1:0]                    out_pay
);

    localparam int SQW = 2 * COORD_BITS;
    localparam int SW  = gpd_pkg::SUM_BITS;
    localparam int RB  = gpd_pkg::ROOT_BITS;
    localparam int RMB = gpd_pkg::REM_BITS;
    localparam int N   = gpd_pkg::ROOT_STEPS;
    localparam int NZ  = gpd_pkg::ROOT_ZERO_STEPS;

    logic [SQW-1:0]      sq_y_reg, sq_z_reg;
    logic [PAY_BITS-1:0] sq_pay_reg;
    logic                sq_valid_reg;
    logic [SW-1:0]       sum_reg;
    logic [PAY_BITS-1:0] sum_pay_reg;
    logic                sum_valid_reg;

    logic [RMB-1:0]      rem_w  [0:N];
    logic [RB-1:0]       root_w [0:N];
    logic [SW-1:0]       s_w    [0:N];
    logic [PAY_BITS-1:0] pay_w  [0:N];
    logic                v_w    [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_y_reg    <= SQW'(in_ay) * SQW'(in_ay);
            sq_z_reg    <= SQW'(in_az) * SQW'(in_az);
            sq_pay_reg  <= in_pay;
            sum_reg     <= SW'(sq_y_reg) + SW'(sq_z_reg);
            sum_pay_reg <= sq_pay_reg;
        end
    end

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign s_w[0]    = sum_reg;
    assign pay_w[0]  = sum_pay_reg;
    assign v_w[0]    = sum_valid_reg;

    for (genvar j = 0; j < N; j++)
    begin : g_step
        localparam int IDX = N - 1 - j;

        logic [1:0]          pair;
        logic [RMB-1:0]      rem_sh, trial;
        logic [RMB-1:0]      rem_next;
        logic [RB-1:0]       root_next;
        logic [RMB-1:0]      rem_reg;
        logic [RB-1:0]       root_reg;
        logic [SW-1:0]       s_reg;
        logic [PAY_BITS-1:0] pay_reg;
        logic                valid_reg;

        if (IDX >= NZ)
        begin : g_pair
            assign pair = s_w[j][2*(IDX-NZ) +: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh = {rem_w[j][RMB-3:0], pair};
            trial  = RMB'({root_w[j], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_w[j][RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_w[j][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= v_w[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                s_reg    <= s_w[j];
                pay_reg  <= pay_w[j];
            end
        end

        assign rem_w[j+1]  = rem_reg;
        assign root_w[j+1] = root_reg;
        assign s_w[j+1]    = s_reg;
        assign pay_w[j+1]  = pay_reg;
        assign v_w[j+1]    = valid_reg;
    end

    assign out_valid = v_w[N];
    assign out_root  = root_w[N];
    assign out_pay   = pay_w[N];

endmodule

`default_nettype wire

// File: hdl/gpd_atan.sv
// Pipelined arctangent of num/den for nonnegative operands: operand
// normalization over three stages, then one CORDIC vectoring step per stage.
// Depends on gpd_pkg.
`default_nettype none

module gpd_atan (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic [gpd_pkg::ATAN_IN_BITS-1:0]      in_num,
    input  wire logic [gpd_pkg::ATAN_IN_BITS-1:0]      in_den,
    input  wire logic                                  in_neg,
    output logic                                       out_valid,
    output logic [gpd_pkg::ANGLE_MAG_BITS-1:0]         out_mag,
    output logic                                       out_neg
);

    localparam int AIW = gpd_pkg::ATAN_IN_BITS;
    localparam int NB  = gpd_pkg::NORM_BITS;
    localparam int NS  = gpd_pkg::NORM_STAGES;
    localparam int CS  = gpd_pkg::CORDIC_STEPS;
    localparam int CB  = gpd_pkg::CORDIC_BITS;
    localparam int AB  = gpd_pkg::ACC_BITS;
    localparam int MB  = gpd_pkg::ANGLE_MAG_BITS;

    logic [AIW-1:0] num_reg, den_reg;
    logic           neg_reg, valid_reg;

    logic [NB-1:0] n_w   [0:NS];
    logic [NB-1:0] d_w   [0:NS];
    logic          nz_w  [0:NS];
    logic          dz_w  [0:NS];
    logic          ng_w  [0:NS];
    logic          nv_w  [0:NS];

    logic signed [CB-1:0] cx_w  [0:CS];
    logic signed [CB-1:0] cy_w  [0:CS];
    logic signed [AB-1:0] acc_w [0:CS];
    logic                 cnz_w [0:CS];
    logic                 cdz_w [0:CS];
    logic                 cng_w [0:CS];
    logic                 cv_w  [0:CS];

    logic [MB-1:0] mag_next, mag_reg;
    logic          out_neg_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= in_num;
            den_reg <= in_den;
            neg_reg <= in_neg;
        end
    end

    assign n_w[0]  = NB'(num_reg);
    assign d_w[0]  = NB'(den_reg);
    assign nz_w[0] = (num_reg != '0);
    assign dz_w[0] = (den_reg == '0);
    assign ng_w[0] = neg_reg;
    assign nv_w[0] = valid_reg;

    // Each stage tries two shifts of a binary leading-zero search, so the larger
    // operand ends up with its top bit at position NB-1.
    for (genvar k = 0; k < NS; k++)
    begin : g_norm
        localparam int SH_A = 32 >> (2 * k);
        localparam int SH_B = 32 >> (2 * k + 1);

        logic [NB-1:0] m_a, n_a, d_a, m_b, n_next, d_next;
        logic [NB-1:0] n_reg, d_reg;
        logic          nz_reg, dz_reg, ng_reg, v_reg;

        always_comb
        begin
            m_a = (n_w[k] > d_w[k]) ? n_w[k] : d_w[k];
            if ((m_a >> (NB - SH_A)) == '0)
            begin
                n_a = n_w[k] << SH_A;
                d_a = d_w[k] << SH_A;
            end
            else
            begin
                n_a = n_w[k];
                d_a = d_w[k];
            end
            m_b = (n_a > d_a) ? n_a : d_a;
            if ((m_b >> (NB - SH_B)) == '0)
            begin
                n_next = n_a << SH_B;
                d_next = d_a << SH_B;
            end
            else
            begin
                n_next = n_a;
                d_next = d_a;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= nv_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg  <= n_next;
                d_reg  <= d_next;
                nz_reg <= nz_w[k];
                dz_reg <= dz_w[k];
                ng_reg <= ng_w[k];
            end
        end

        assign n_w[k+1]  = n_reg;
        assign d_w[k+1]  = d_reg;
        assign nz_w[k+1] = nz_reg;
        assign dz_w[k+1] = dz_reg;
        assign ng_w[k+1] = ng_reg;
        assign nv_w[k+1] = v_reg;
    end

    assign cx_w[0]  = signed'(CB'(d_w[NS]));
    assign cy_w[0]  = signed'(CB'(n_w[NS]));
    assign acc_w[0] = '0;
    assign cnz_w[0] = nz_w[NS];
    assign cdz_w[0] = dz_w[NS];
    assign cng_w[0] = ng_w[NS];
    assign cv_w[0]  = nv_w[NS];

    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        localparam logic signed [AB-1:0] STEP = AB'(gpd_pkg::atan_step(i));

        logic signed [CB-1:0] cx_next, cy_next, cx_reg, cy_reg;
        logic signed [AB-1:0] acc_next, acc_reg;
        logic                 nz_reg, dz_reg, ng_reg, v_reg;

        always_comb
        begin
            if (cy_w[i] > 0)
            begin
                cx_next  = cx_w[i] + (cy_w[i] >>> i);
                cy_next  = cy_w[i] - (cx_w[i] >>> i);
                acc_next = acc_w[i] + STEP;
            end
            else
            begin
                cx_next  = cx_w[i] - (cy_w[i] >>> i);
                cy_next  = cy_w[i] + (cx_w[i] >>> i);
                acc_next = acc_w[i] - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= cv_w[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg  <= cx_next;
                cy_reg  <= cy_next;
                acc_reg <= acc_next;
                nz_reg  <= cnz_w[i];
                dz_reg  <= cdz_w[i];
                ng_reg  <= cng_w[i];
            end
        end

        assign cx_w[i+1]  = cx_reg;
        assign cy_w[i+1]  = cy_reg;
        assign acc_w[i+1] = acc_reg;
        assign cnz_w[i+1] = nz_reg;
        assign cdz_w[i+1] = dz_reg;
        assign cng_w[i+1] = ng_reg;
        assign cv_w[i+1]  = v_reg;
    end

    // A zero numerator gives zero; a zero denominator gives a right angle.
    always_comb
    begin
        if (!cnz_w[CS])
            mag_next = '0;
        else if (cdz_w[CS])
            mag_next = gpd_pkg::QUARTER_PI;
        else if (acc_w[CS] < 0)
            mag_next = '0;
        else if (acc_w[CS] > signed'(AB'(gpd_pkg::QUARTER_PI)))
            mag_next = gpd_pkg::QUARTER_PI;
        else
            mag_next = acc_w[CS][MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cv_w[CS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            out_neg_reg <= cng_w[CS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = out_neg_reg;

endmodule

`default_nettype wire

// File: hdl/gpd_dac.sv
// Clamps one angle to the limit and maps it onto a DAC code through a
// pipelined restoring divider, one quotient bit per stage. Depends on gpd_pkg.
`default_nettype none

module gpd_dac #(
    parameter int DAC_BITS = gpd_pkg::DAC_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic [gpd_pkg::ANGLE_MAG_BITS-1:0]    lim,
    input  wire logic                                  inv,
    input  wire logic                                  in_valid,
    input  wire logic [gpd_pkg::ANGLE_MAG_BITS-1:0]    in_mag,
    input  wire logic                                  in_neg,
    output logic                                       out_valid,
    output logic [DAC_BITS-1:0]                        out_code,
    output logic signed [gpd_pkg::ANGLE_BITS-1:0]      out_angle
);

    localparam int MB  = gpd_pkg::ANGLE_MAG_BITS;
    localparam int AB  = gpd_pkg::ANGLE_BITS;
    localparam int NMB = gpd_pkg::NUM_BITS;
    localparam int PW  = NMB + DAC_BITS;

    logic [MB-1:0]         mag_c;
    logic signed [AB-1:0]  angle_next, angle1_reg, angle2_reg;
    logic [NMB-1:0]        num_next, num_reg;
    logic [PW-1:0]         prod_reg;
    logic                  v1_reg, v2_reg;

    logic [PW-1:0]         r_w [0:DAC_BITS];
    logic [DAC_BITS-1:0]   q_w [0:DAC_BITS];
    logic signed [AB-1:0]  a_w [0:DAC_BITS];
    logic                  v_w [0:DAC_BITS];

    always_comb
    begin
        mag_c      = (in_mag > lim) ? lim : in_mag;
        angle_next = in_neg ? -signed'(AB'(mag_c)) : signed'(AB'(mag_c));
        // Inverted mapping is the limit minus the angle, normal is plus.
        if (in_neg ^ inv)
            num_next = NMB'(lim) - NMB'(mag_c);
        else
            num_next = NMB'(lim) + NMB'(mag_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= num_next;
            angle1_reg <= angle_next;
            prod_reg   <= (PW'(num_reg) << DAC_BITS) - PW'(num_reg);
            angle2_reg <= angle1_reg;
        end
    end

    assign r_w[0] = prod_reg;
    assign q_w[0] = '0;
    assign a_w[0] = angle2_reg;
    assign v_w[0] = v2_reg;

    for (genvar j = 0; j < DAC_BITS; j++)
    begin : g_div
        localparam int BIT = DAC_BITS - 1 - j;

        logic [PW-1:0]        dsh;
        logic [PW-1:0]        r_next, r_reg;
        logic [DAC_BITS-1:0]  q_next, q_reg;
        logic signed [AB-1:0] a_reg;
        logic                 v_reg;

        always_comb
        begin
            dsh    = PW'({lim, 1'b0}) << BIT;
            r_next = r_w[j];
            q_next = q_w[j];
            if (r_w[j] >= dsh)
            begin
                r_next      = r_w[j] - dsh;
                q_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v_w[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg <= r_next;
                q_reg <= q_next;
                a_reg <= a_w[j];
            end
        end

        assign r_w[j+1] = r_reg;
        assign q_w[j+1] = q_reg;
        assign a_w[j+1] = a_reg;
        assign v_w[j+1] = v_reg;
    end

    assign out_valid = v_w[DAC_BITS];
    assign out_code  = q_w[DAC_BITS];
    assign out_angle = a_w[DAC_BITS];

endmodule

`default_nettype wire

// File: hdl/galvo_point_to_dac.sv
// Top level of the galvo point-to-DAC block: register port, input stage,
// root, two arctangent pipes, two DAC mappers and the output register.
// Depends on gpd_pkg, gpd_point_if, gpd_result_if, gpd_sqrt, gpd_atan, gpd_dac.
//
//   Channel   Kind       Payload
//   point     sink       coord_x, coord_y, coord_z (signed Q15.8)
//   result    source     dac_x, dac_z, angle_x, angle_z
//   APB       slave      mirror_offset, angle_limit, invert_x, invert_z
//
// One point is accepted per clock while the output is not stalled. A point passes
// through the input registers, the digit-by-digit root, normalization and CORDIC,
// the mapping and the output register. The whole pipeline advances together and
// holds only while a finished transaction waits at the output register.
// Reset clears the valid bits and loads the register defaults; there is no
// clearing pass.
`default_nettype none

module galvo_point_to_dac #(
    parameter int COORD_BITS = gpd_pkg::COORD_BITS,
    parameter int DAC_BITS   = gpd_pkg::DAC_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gpd_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [gpd_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [gpd_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                      pready,
    gpd_point_if.sink                                 point,
    gpd_result_if.source                              result
);

    localparam int MB  = gpd_pkg::ANGLE_MAG_BITS;
    localparam int OB  = gpd_pkg::OFFSET_BITS;
    localparam int AIW = gpd_pkg::ATAN_IN_BITS;
    localparam int FS  = gpd_pkg::FRAC_SHIFT;
    localparam int PB  = 3 * COORD_BITS + 2;
    localparam int DW  = gpd_pkg::APB_DATA_BITS;

    logic [OB-1:0]  mirror_offset_reg;
    logic [MB-1:0]  angle_limit_reg;
    logic           invert_x_reg, invert_z_reg;
    logic [MB-1:0]  lim_eff;
    gpd_pkg::reg_index_t reg_idx;

    logic en;

    logic [COORD_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic                  xneg_reg, zneg_reg, in_valid_reg;

    logic                          sq_valid;
    logic [gpd_pkg::ROOT_BITS-1:0] sq_root;
    logic [PB-1:0]                 sq_pay;
    logic [COORD_BITS-1:0]         p_ax, p_ay, p_az;
    logic                          p_xneg, p_zneg;

    logic          atx_valid, atz_valid, atx_neg, atz_neg;
    logic [MB-1:0] atx_mag, atz_mag;

    logic                                 dx_valid, dz_valid;
    logic [DAC_BITS-1:0]                  dx_code, dz_code;
    logic signed [gpd_pkg::ANGLE_BITS-1:0] dx_angle, dz_angle;

    logic                                  res_valid_reg;
    logic [DAC_BITS-1:0]                   dac_x_reg, dac_z_reg;
    logic signed [gpd_pkg::ANGLE_BITS-1:0] angle_x_reg, angle_z_reg;

    // Register port.
    assign reg_idx = gpd_pkg::reg_index_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_offset_reg <= '0;
            angle_limit_reg   <= gpd_pkg::LIMIT_RESET;
            invert_x_reg      <= 1'b0;
            invert_z_reg      <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                gpd_pkg::REG_MIRROR_OFFSET: mirror_offset_reg <= pwdata[OB-1:0];
                gpd_pkg::REG_ANGLE_LIMIT:   angle_limit_reg   <= pwdata[MB-1:0];
                gpd_pkg::REG_INVERT_X:      invert_x_reg      <= pwdata[0];
                gpd_pkg::REG_INVERT_Z:      invert_z_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gpd_pkg::REG_MIRROR_OFFSET: prdata = DW'(mirror_offset_reg);
            gpd_pkg::REG_ANGLE_LIMIT:   prdata = DW'(angle_limit_reg);
            gpd_pkg::REG_INVERT_X:      prdata = DW'(invert_x_reg);
            gpd_pkg::REG_INVERT_Z:      prdata = DW'(invert_z_reg);
            default:                    prdata = '0;
        endcase
    end

    // A zero limit behaves as one.
    assign lim_eff = (angle_limit_reg == '0) ? MB'(1) : angle_limit_reg;

    assign en          = !res_valid_reg || result.ready;
    assign point.ready = en;

    // Input stage: magnitudes and signs. The vertical sign is sign(z) xor sign(y).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= point.coord_x[COORD_BITS-1] ? -point.coord_x : point.coord_x;
            ay_reg   <= point.coord_y[COORD_BITS-1] ? -point.coord_y : point.coord_y;
            az_reg   <= point.coord_z[COORD_BITS-1] ? -point.coord_z : point.coord_z;
            xneg_reg <= point.coord_x[COORD_BITS-1];
            zneg_reg <= point.coord_z[COORD_BITS-1] ^ point.coord_y[COORD_BITS-1];
        end
    end

    gpd_sqrt #(
        .COORD_BITS (COORD_BITS),
        .PAY_BITS   (PB)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_ay     (ay_reg),
        .in_az     (az_reg),
        .in_pay    ({ax_reg, ay_reg, az_reg, xneg_reg, zneg_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pay   (sq_pay)
    );

    assign {p_ax, p_ay, p_az, p_xneg, p_zneg} = sq_pay;

    gpd_atan u_atan_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (AIW'(p_ax) << FS),
        .in_den    ((AIW'(mirror_offset_reg) << FS) + AIW'(sq_root)),
        .in_neg    (p_xneg),
        .out_valid (atx_valid),
        .out_mag   (atx_mag),
        .out_neg   (atx_neg)
    );

    gpd_atan u_atan_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (AIW'(p_az)),
        .in_den    (AIW'(p_ay)),
        .in_neg    (p_zneg),
        .out_valid (atz_valid),
        .out_mag   (atz_mag),
        .out_neg   (atz_neg)
    );

    gpd_dac #(
        .DAC_BITS (DAC_BITS)
    ) u_dac_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .lim       (lim_eff),
        .inv       (invert_x_reg),
        .in_valid  (atx_valid),
        .in_mag    (atx_mag),
        .in_neg    (atx_neg),
        .out_valid (dx_valid),
        .out_code  (dx_code),
        .out_angle (dx_angle)
    );

    gpd_dac #(
        .DAC_BITS (DAC_BITS)
    ) u_dac_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .lim       (lim_eff),
        .inv       (invert_z_reg),
        .in_valid  (atz_valid),
        .in_mag    (atz_mag),
        .in_neg    (atz_neg),
        .out_valid (dz_valid),
        .out_code  (dz_code),
        .out_angle (dz_angle)
    );

    // Both lanes run in lockstep, so their valid bits always agree.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dx_valid && dz_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dac_x_reg   <= dx_code;
            dac_z_reg   <= dz_code;
            angle_x_reg <= dx_angle;
            angle_z_reg <= dz_angle;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.dac_x   = dac_x_reg;
    assign result.dac_z   = dac_z_reg;
    assign result.angle_x = angle_x_reg;
    assign result.angle_z = angle_z_reg;

endmodule

`default_nettype wire

// File: hdl/gpd_checker.sv
// Port-level checks for the galvo point-to-DAC block and the bind that
// attaches them to the top level. Depends on gpd_pkg and galvo_point_to_dac.
`default_nettype none

module gpd_checker #(
    parameter int DAC_BITS = gpd_pkg::DAC_BITS
) (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_ready,
    input wire logic                                  res_valid,
    input wire logic                                  res_ready,
    input wire logic [DAC_BITS-1:0]                   dac_x,
    input wire logic [DAC_BITS-1:0]                   dac_z,
    input wire logic signed [gpd_pkg::ANGLE_BITS-1:0] angle_x,
    input wire logic signed [gpd_pkg::ANGLE_BITS-1:0] angle_z
);

    localparam logic [DAC_BITS-1:0] MID = DAC_BITS'(((1 << DAC_BITS) - 1) / 2);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(dac_x) && $stable(dac_z)
            && $stable(angle_x) && $stable(angle_z))
        else $error("result payload changed while stalled");

    // A zero angle sits at the middle of the range for either direction.
    a_mid_x: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && angle_x == 0 |-> dac_x == MID)
        else $error("zero horizontal angle not mapped to midscale");

    a_mid_z: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && angle_z == 0 |-> dac_z == MID)
        else $error("zero vertical angle not mapped to midscale");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> res_valid && !res_ready)
        else $error("input stalled without a waiting result");

endmodule

bind galvo_point_to_dac gpd_checker #(
    .DAC_BITS (DAC_BITS)
) u_gpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (point.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .dac_x     (result.dac_x),
    .dac_z     (result.dac_z),
    .angle_x   (result.angle_x),
    .angle_z   (result.angle_z)
);

`default_nettype wire

// File: test/gpd_checker.sv
// Checker for the galvo point-to-DAC block: watches both channels, predicts
// each result from the accepted point and the register copy, and compares.
// Depends on gpd_pkg, gpd_point_if and gpd_result_if.
module gpd_scoreboard (
    input  logic                    clk,
    input  logic                    rst_n,
    gpd_point_if.sink               point,
    gpd_result_if.sink              result,
    input  logic [22:0]             mirror_offset,
    input  logic [16:0]             angle_limit,
    input  logic                    invert_x,
    input  logic                    invert_z,
    output int                      errors,
    output int                      pending,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0]        dac_x;
        logic [11:0]        dac_z;
        logic signed [17:0] angle_x;
        logic signed [17:0] angle_z;
    } aim_t;

    aim_t expected_aims[$];

    // floor(sqrt(s * 2^16)), digit by digit.
    function automatic logic [63:0] root_q16(input logic [63:0] s);
        logic [63:0] rem, root, trial, pair;
        rem = 0;
        root = 0;
        for (int i = 39; i >= 0; i--) begin
            pair = (i >= 8) ? ((s >> (2 * (i - 8))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic longint atan_of(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] m;
        longint cx, cy, acc, dx, dy;
        acc = 0;
        if (n == 0)
            return 0;
        if (d == 0)
            return gpd_pkg::QUARTER_PI;
        m = (n > d) ? n : d;
        while (m < (64'd1 << 57)) begin
            n = n << 1;
            d = d << 1;
            m = m << 1;
        end
        cx = d;
        cy = n;
        for (int i = 0; i < 17; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx;
                cy -= dy;
                acc += gpd_pkg::atan_step(i);
            end
            else begin
                cx -= dx;
                cy += dy;
                acc -= gpd_pkg::atan_step(i);
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > gpd_pkg::QUARTER_PI)
            acc = gpd_pkg::QUARTER_PI;
        return acc;
    endfunction

    function automatic logic [11:0] dac_code(input longint a, input longint lim,
                                             input logic inv);
        longint num;
        num = inv ? (lim - a) : (a + lim);
        return 12'((num * 4095) / (2 * lim));
    endfunction

    function automatic aim_t aim_point(input longint x, input longint y, input longint z);
        aim_t r;
        longint lim, ax, ay, az, az_ang, ax_ang;
        logic [63:0] rad;
        lim = (angle_limit == 0) ? 1 : longint'(angle_limit);
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        rad = root_q16(ay * ay + az * az);
        az_ang = atan_of(az, ay);
        if (((z < 0) != (y < 0) && y != 0) || (y == 0 && z < 0))
            az_ang = -az_ang;
        ax_ang = atan_of(ax << 8, (longint'(mirror_offset) << 8) + rad);
        if (x < 0)
            ax_ang = -ax_ang;
        if (az_ang > lim) az_ang = lim;
        if (az_ang < -lim) az_ang = -lim;
        if (ax_ang > lim) ax_ang = lim;
        if (ax_ang < -lim) ax_ang = -lim;
        r.dac_x = dac_code(ax_ang, lim, invert_x);
        r.dac_z = dac_code(az_ang, lim, invert_z);
        r.angle_x = 18'(ax_ang);
        r.angle_z = 18'(az_ang);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        aim_t want, got;
        if (!rst_n) begin
            errors <= 0;
            checked <= 0;
            pending <= 0;
        end
        else begin
            if (point.valid && point.ready)
                expected_aims.push_back(aim_point(point.coord_x, point.coord_y,
                                                  point.coord_z));
            if (result.valid && result.ready) begin
                got = '{result.dac_x, result.dac_z, result.angle_x, result.angle_z};
                checked <= checked + 1;
                if (expected_aims.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result %p", $time, got);
                    errors <= errors + 1;
                end
                else begin
                    want = expected_aims.pop_front();
                    if (want !== got) begin
                        if (errors < 10)
                            $display("%0t: mismatch expected %p got %p", $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_aims.size();
        end
    end
endmodule

// File: test/galvo_point_to_dac_test.sv
// Top of the galvo point-to-DAC testbench: clock, reset, register writes,
// point stimulus and verdict. Depends on gpd_pkg, the channel interfaces,
// the block and gpd_scoreboard.
module galvo_point_to_dac_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic [22:0] offset_copy;
    logic [16:0] limit_copy;
    logic        inv_x_copy, inv_z_copy;
    int          errors, pending, checked;
    int          stall_mode;

    gpd_point_if  point ();
    gpd_result_if result ();

    galvo_point_to_dac dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .point(point.sink), .result(result.source)
    );

    gpd_scoreboard u_scoreboard (
        .clk, .rst_n, .point(point.sink), .result(result.sink),
        .mirror_offset(offset_copy), .angle_limit(limit_copy),
        .invert_x(inv_x_copy), .invert_z(inv_z_copy),
        .errors, .pending, .checked
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver's stall pattern changes with each phase; in mode 0 it never stalls.
    always @(negedge clk) begin
        case (stall_mode)
            0: result.ready <= 1'b1;
            1: result.ready <= ($urandom_range(3) != 0);
            2: result.ready <= ($urandom_range(3) == 0);
            default: result.ready <= ~result.ready;
        endcase
    end

    task automatic write_reg(input gpd_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            gpd_pkg::REG_MIRROR_OFFSET: offset_copy = value[22:0];
            gpd_pkg::REG_ANGLE_LIMIT:   limit_copy = value[16:0];
            gpd_pkg::REG_INVERT_X:      inv_x_copy = value[0];
            default:                    inv_z_copy = value[0];
        endcase
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z);
        point.valid <= 1;
        point.coord_x <= x;
        point.coord_y <= y;
        point.coord_z <= z;
        @(posedge clk);
        while (!point.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        point.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Moderate coordinates half the time, else full-range, small or zero ones.
    function automatic logic [23:0] pick_coord();
        case ($urandom_range(5))
            0:       return 24'($urandom);
            1:       return 24'($signed($urandom_range(511)) - 256);
            2:       return 24'd0;
            default: return 24'($signed($urandom_range(131071)) - 65536);
        endcase
    endfunction

    // The caller drops valid afterwards, by drain.
    task automatic random_burst(input int count);
        int gap;
        while (count > 0) begin
            for (int b = $urandom_range(1, 30); b > 0 && count > 0; b--) begin
                send_point(pick_coord(), pick_coord(), pick_coord());
                count--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                point.valid <= 0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    logic [23:0] corners [7] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001,
                                 24'hFFFFFF, 24'h000100, 24'hFFFF00};

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        point.valid = 0; point.coord_x = 0; point.coord_y = 0; point.coord_z = 0;
        result.ready = 1;
        stall_mode = 0;
        offset_copy = 0; limit_copy = gpd_pkg::LIMIT_RESET;
        inv_x_copy = 0; inv_z_copy = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, zero over zero, zero denominators, sign mixes.
        for (int i = 0; i < 7; i++)
            send_point(corners[i], corners[(i + 3) % 7], corners[(i * 2 + 1) % 7]);
        send_point(24'd0, 24'd0, 24'd0);
        send_point(24'h000500, 24'd0, 24'hFFF000);
        send_point(24'h800000, 24'h800000, 24'h800000);
        send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        drain();

        write_reg(gpd_pkg::REG_MIRROR_OFFSET, 32'h7FFFFF);
        write_reg(gpd_pkg::REG_ANGLE_LIMIT, 32'd102943);
        write_reg(gpd_pkg::REG_INVERT_X, 32'd1);
        write_reg(gpd_pkg::REG_INVERT_Z, 32'd1);
        stall_mode = 1;
        for (int i = 0; i < 7; i++)
            send_point(corners[i], corners[(i + 5) % 7], corners[i]);
        random_burst(300);
        drain();

        // Zero limit acts as one; above the quarter turn is used as written.
        write_reg(gpd_pkg::REG_ANGLE_LIMIT, 32'd0);
        write_reg(gpd_pkg::REG_MIRROR_OFFSET, 32'd0);
        stall_mode = 2;
        random_burst(100);
        drain();

        write_reg(gpd_pkg::REG_ANGLE_LIMIT, 32'h1FFFF);
        write_reg(gpd_pkg::REG_INVERT_X, 32'd0);
        stall_mode = 3;
        random_burst(300);
        drain();

        write_reg(gpd_pkg::REG_ANGLE_LIMIT, 32'd1);
        write_reg(gpd_pkg::REG_INVERT_Z, 32'd0);
        write_reg(gpd_pkg::REG_MIRROR_OFFSET, 32'd25600);
        stall_mode = 1;
        random_burst(100);
        drain();

        write_reg(gpd_pkg::REG_ANGLE_LIMIT, 32'($urandom_range(1, 102943)));
        write_reg(gpd_pkg::REG_MIRROR_OFFSET, 32'($urandom_range(0, 8388607)));
        stall_mode = 0;
        random_burst(400);
        drain();

        $display("Checked %0d results over six register settings,", checked);
        $display("including limit and offset extremes and both mapping directions.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
